// ===== rtl/lpr_pkg.sv =====
// ============================================================================
// lpr_pkg
// Shared constants, codes and types for the longest-prefix route lookup.
// ============================================================================
package lpr_pkg;

    // Table geometry
    localparam int ENTRIES   = 16;
    localparam int NUM_PORTS = 4;
    localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int MAC_W   = 48;
    localparam int PORT_W  = 2;
    localparam int LEN_W   = 6;
    localparam int INDEX_W = 4;

    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
    localparam logic [MAC_W-1:0]  MAC_ONES  = {MAC_W{1'b1}};

    // Command codes
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    // Item travelling down the cell chain. A write carries the route to
    // store; a lookup carries the best route found so far in mac/port/len.
    typedef struct packed {
        logic                vld;
        logic                lookup;
        logic                bcast;
        logic [SLOT_W-1:0]   idx;
        logic                wr_valid;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   lead;
        logic [LEN_W-1:0]    len;
        logic [MAC_W-1:0]    mac;
        logic [PORT_W-1:0]   port;
        logic                found;
    } t_tok;

    // Thermometer of the leading run of ones: bit i set when all mask bits
    // from 31 down to i are ones. Each bit is an independent check.
    function automatic logic [ADDR_W-1:0] lead_run(input logic [ADDR_W-1:0] mask);
        logic [ADDR_W-1:0] run;
        logic [ADDR_W-1:0] low;
        for (int i = 0; i < ADDR_W; i++) begin
            low    = ~(ADDR_ONES << i);
            run[i] = &(mask | low);
        end
        return run;
    endfunction

endpackage

// ===== rtl/lpr_if.sv =====
// ============================================================================
// lpr_req_if / lpr_rsp_if
// Valid/ready channels for lookup and write requests and for lookup results.
// ============================================================================
interface lpr_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [lpr_pkg::INDEX_W-1:0]  entry_index;
    logic                         entry_valid;
    logic [lpr_pkg::ADDR_W-1:0]   addr;
    logic [lpr_pkg::ADDR_W-1:0]   prefix_mask;
    logic [lpr_pkg::MAC_W-1:0]    hop_mac;
    logic [lpr_pkg::PORT_W-1:0]   port_in;

    modport source (output valid, cmd, entry_index, entry_valid, addr, prefix_mask,
                    hop_mac, port_in, input ready);
    modport sink   (input valid, cmd, entry_index, entry_valid, addr, prefix_mask,
                    hop_mac, port_in, output ready);
endinterface

interface lpr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         broadcast;
    logic [lpr_pkg::MAC_W-1:0]    next_hop;
    logic [lpr_pkg::PORT_W-1:0]   out_port;
    logic [lpr_pkg::LEN_W-1:0]    prefix_len;

    modport source (output valid, hit, broadcast, next_hop, out_port, prefix_len,
                    input ready);
    modport sink   (input valid, hit, broadcast, next_hop, out_port, prefix_len,
                    output ready);
endinterface

// ===== rtl/lpr_cell.sv =====
// ============================================================================
// lpr_cell
// One route slot of the chain: stores its route and scores each passing
// lookup against it, handing the item on to the next cell.
// ============================================================================
module lpr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [lpr_pkg::SLOT_W-1:0]  i_slot_id,
    input  lpr_pkg::t_tok               i_tok,
    output lpr_pkg::t_tok               o_tok
);

    logic                          r_slot_valid;
    logic [lpr_pkg::ADDR_W-1:0]    r_prefix;
    logic [lpr_pkg::ADDR_W-1:0]    r_lead;
    logic [lpr_pkg::LEN_W-1:0]     r_len;
    logic [lpr_pkg::MAC_W-1:0]     r_mac;
    logic [lpr_pkg::PORT_W-1:0]    r_port;
    lpr_pkg::t_tok                 r_tok;
    lpr_pkg::t_tok                 n_tok;

    logic wr_here;
    logic better;

    assign wr_here = i_tok.vld && !i_tok.lookup && (i_tok.idx == i_slot_id);

    // Strictly longer wins, so earlier (lower) slots keep ties
    assign better = i_tok.vld && i_tok.lookup && !i_tok.bcast && r_slot_valid
                 && (((i_tok.addr ^ r_prefix) & r_lead) == '0)
                 && (!i_tok.found || (r_len > i_tok.len));

    // Score the passing item
    always_comb begin
        n_tok = i_tok;
        if (better) begin
            n_tok.found = 1'b1;
            n_tok.len   = r_len;
            n_tok.mac   = r_mac;
            n_tok.port  = r_port;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= 1'b0;
        end else if (i_adv && wr_here) begin
            r_slot_valid <= i_tok.wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && wr_here) begin
            r_prefix <= i_tok.addr;
            r_lead   <= i_tok.lead;
            r_len    <= i_tok.len;
            r_mac    <= i_tok.mac;
            r_port   <= i_tok.port;
        end
    end

    // Hand-off register to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/longest_prefix_route_lookup.sv =====
// ============================================================================
// longest_prefix_route_lookup
// Longest-prefix IPv4 route table built as a chain of slot cells.
// ============================================================================
//  channel  | dir | carries
//  ---------+-----+-----------------------------------------------------------
//  i_req    | in  | cmd, entry_index, entry_valid, addr, prefix_mask, hop_mac,
//           |     | port_in (write a slot or look up a destination)
//  o_rsp    | out | hit, broadcast, next_hop, out_port, prefix_len
//
// While the chain is not held, one item enters per cycle and each moves one
// cell per cycle through the hand-off registers into the result register.
// Writes share the chain, so each lookup sees exactly the writes before it.
// Synchronous reset clears all slot valid marks and empties the chain.
// When a result waits in the output register and o_rsp is not ready, the
// whole chain holds and i_req is not ready.
module longest_prefix_route_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpr_req_if.sink     i_req,
    lpr_rsp_if.source   o_rsp
);

    lpr_pkg::t_tok tok [0:lpr_pkg::ENTRIES];
    lpr_pkg::t_tok in_tok;
    lpr_pkg::t_tok last;

    logic                               adv;
    logic                               is_lookup;
    logic                               wr_ok;
    logic [lpr_pkg::ADDR_W-1:0]         run;

    logic                               r_out_vld;
    logic                               r_hit;
    logic                               r_bcast;
    logic [lpr_pkg::MAC_W-1:0]          r_mac;
    logic [lpr_pkg::PORT_W-1:0]         r_port;
    logic [lpr_pkg::LEN_W-1:0]          r_len;

    // Chain moves whenever the output register can take what falls out;
    // no transfer is taken while in reset
    assign adv         = !r_out_vld || o_rsp.ready;
    assign i_req.ready = adv && i_rst_n;

    assign is_lookup = (lpr_pkg::t_cmd'(i_req.cmd) == lpr_pkg::CMD_LOOKUP);
    assign wr_ok     = ({5'b0, i_req.entry_index} < 9'(lpr_pkg::ENTRIES))
                    && ({3'b0, i_req.port_in} < 5'(lpr_pkg::NUM_PORTS));
    assign run       = lpr_pkg::lead_run(i_req.prefix_mask);

    // Build the item for the first cell; out-of-range writes are dropped
    always_comb begin
        in_tok          = '0;
        in_tok.vld      = i_req.valid && (is_lookup || wr_ok);
        in_tok.lookup   = is_lookup;
        in_tok.bcast    = (i_req.addr == lpr_pkg::ADDR_ONES);
        in_tok.idx      = lpr_pkg::SLOT_W'({{lpr_pkg::SLOT_W{1'b0}}, i_req.entry_index});
        in_tok.wr_valid = i_req.entry_valid;
        in_tok.addr     = i_req.addr;
        in_tok.found    = 1'b0;
        if (!is_lookup) begin
            in_tok.lead = run;
            in_tok.len  = lpr_pkg::LEN_W'($countones(run));
            in_tok.mac  = i_req.hop_mac;
            in_tok.port = i_req.port_in;
        end
    end

    assign tok[0] = in_tok;

    // Row of slot cells
    for (genvar k = 0; k < lpr_pkg::ENTRIES; k++) begin : g_cell
        lpr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_slot_id (lpr_pkg::SLOT_W'(k)),
            .i_tok     (tok[k]),
            .o_tok     (tok[k+1])
        );
    end

    assign last = tok[lpr_pkg::ENTRIES];

    // Result register: lookups that leave the chain; writes end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= last.vld && last.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bcast <= last.bcast;
            r_hit   <= !last.bcast && last.found;
            r_mac   <= last.bcast ? lpr_pkg::MAC_ONES : (last.found ? last.mac : '0);
            r_port  <= (!last.bcast && last.found) ? last.port : '0;
            r_len   <= (!last.bcast && last.found) ? last.len  : '0;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.broadcast  = r_bcast;
    assign o_rsp.next_hop   = r_mac;
    assign o_rsp.out_port   = r_port;
    assign o_rsp.prefix_len = r_len;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the longest-prefix route lookup. It sends route
// writes and destination lookups over the request channel. A local copy of
// the route table predicts every lookup result, and each result field is
// compared in order. Both channels idle at random. One long result stall
// fills the chain, and one pause lets the pipe drain completely.
// ============================================================================
module testbench;
    import lpr_pkg::*;

    localparam int RAND_ITEMS  = 1650;
    localparam int CALM_TAIL   = 300;     // last items run with no idling
    localparam int HOLD_AT     = 300;     // long result stall starts here
    localparam int HOLD_BURST  = 60;      // items offered back to back meanwhile
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_AT    = 800;     // sender waits for an empty pipe here
    localparam int CHAIN_LAT   = ENTRIES + 1;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_cmd                cmd;
        logic [INDEX_W-1:0]  entry_index;
        logic                entry_valid;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   prefix_mask;
        logic [MAC_W-1:0]    hop_mac;
        logic [PORT_W-1:0]   port_in;
    } route_req_t;

    typedef struct packed {
        logic               hit;
        logic               broadcast;
        logic [MAC_W-1:0]   next_hop;
        logic [PORT_W-1:0]  out_port;
        logic [LEN_W-1:0]   prefix_len;
    } route_result_t;

    // one stimulus row; want is used only when fixed is set
    typedef struct {
        route_req_t     req;
        bit             fixed;
        route_result_t  want;
    } stim_row_t;

    localparam route_result_t RES_MISS  = '0;
    localparam route_result_t RES_FLOOD = {1'b0, 1'b1, MAC_ONES, {PORT_W{1'b0}},
                                           {LEN_W{1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpr_req_if req ();
    lpr_rsp_if rsp ();

    longest_prefix_route_lookup DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Local route table
    logic              tbl_on     [ENTRIES];
    logic [ADDR_W-1:0] tbl_prefix [ENTRIES];
    logic [ADDR_W-1:0] tbl_mask   [ENTRIES];
    logic [MAC_W-1:0]  tbl_mac    [ENTRIES];
    logic [PORT_W-1:0] tbl_port   [ENTRIES];

    route_result_t answers_q [$];
    stim_row_t     directed_rows [$];
    int            bad_fields = 0;
    int            cycles = 0;
    bit            calm = 1'b0;
    bit            hold_go = 1'b0;

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Length of the leading run of ones in a route mask
    function automatic int mask_run_len(input logic [ADDR_W-1:0] m);
        int n;
        n = 0;
        while (n < ADDR_W && m[ADDR_W-1-n])
            n++;
        return n;
    endfunction

    // Mask with the top n bits set
    function automatic logic [ADDR_W-1:0] run_keep(input int n);
        return (n == 0) ? '0 : ADDR_ONES << (ADDR_W - n);
    endfunction

    function automatic void route_install(input route_req_t r);
        if (r.entry_index < ENTRIES && r.port_in < NUM_PORTS) begin
            tbl_on[r.entry_index]     = r.entry_valid;
            tbl_prefix[r.entry_index] = r.addr;
            tbl_mask[r.entry_index]   = r.prefix_mask;
            tbl_mac[r.entry_index]    = r.hop_mac;
            tbl_port[r.entry_index]   = r.port_in;
        end
    endfunction

    // Longest match wins; a strict compare keeps the lowest slot on ties
    function automatic route_result_t route_resolve(input logic [ADDR_W-1:0] dst);
        route_result_t res;
        int            run;
        int            best_run;
        logic [ADDR_W-1:0] keep;
        res      = RES_MISS;
        best_run = 0;
        if (dst == ADDR_ONES) begin
            res = RES_FLOOD;
        end else begin
            for (int s = 0; s < ENTRIES; s++) begin
                if (tbl_on[s]) begin
                    run  = mask_run_len(tbl_mask[s]);
                    keep = run_keep(run);
                    if (((dst ^ tbl_prefix[s]) & keep) == '0 &&
                        (!res.hit || run > best_run)) begin
                        best_run       = run;
                        res.hit        = 1'b1;
                        res.next_hop   = tbl_mac[s];
                        res.out_port   = tbl_port[s];
                        res.prefix_len = LEN_W'(run);
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic void dir_write(input logic [INDEX_W-1:0] idx, input logic vld,
                                      input logic [ADDR_W-1:0] prefix,
                                      input logic [ADDR_W-1:0] mask,
                                      input logic [MAC_W-1:0] mac,
                                      input logic [PORT_W-1:0] port);
        stim_row_t row;
        row.req             = '0;
        row.req.cmd         = CMD_WRITE;
        row.req.entry_index = idx;
        row.req.entry_valid = vld;
        row.req.addr        = prefix;
        row.req.prefix_mask = mask;
        row.req.hop_mac     = mac;
        row.req.port_in     = port;
        row.fixed           = 1'b0;
        row.want            = RES_MISS;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // junk fills the fields a lookup ignores with ones
    function automatic void dir_lookup(input logic [ADDR_W-1:0] dst, input bit fixed,
                                       input route_result_t want, input bit junk);
        stim_row_t row;
        row.req      = '0;
        row.req.cmd  = CMD_LOOKUP;
        row.req.addr = dst;
        if (junk) begin
            row.req.entry_index = '1;
            row.req.entry_valid = 1'b1;
            row.req.prefix_mask = '1;
            row.req.hop_mac     = '1;
            row.req.port_in     = '1;
        end
        row.fixed = fixed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Offer one item, wait for its transfer, then update the prediction
    task automatic offer(input stim_row_t row, input bit pace);
        int gap;
        if (pace && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= row.req.cmd;
        req.entry_index <= row.req.entry_index;
        req.entry_valid <= row.req.entry_valid;
        req.addr        <= row.req.addr;
        req.prefix_mask <= row.req.prefix_mask;
        req.hop_mac     <= row.req.hop_mac;
        req.port_in     <= row.req.port_in;
        do @(posedge i_clk); while (!req.ready);
        if (row.req.cmd == CMD_WRITE)
            route_install(row.req);
        else if (row.fixed)
            answers_q.insert(answers_q.size(), row.want);
        else
            answers_q.insert(answers_q.size(), route_resolve(row.req.addr));
    endtask

    // Stimulus
    initial begin : stimulus
        stim_row_t         row;
        logic [63:0]       wide;
        logic [ADDR_W-1:0] keep;
        int                run;
        int                pick;
        int                burst;
        int                s;
        for (int i = 0; i < ENTRIES; i++)
            tbl_on[i] = 1'b0;
        i_rst_n         <= 1'b0;
        req.valid       <= 1'b0;
        req.cmd         <= CMD_WRITE;
        req.entry_index <= '0;
        req.entry_valid <= 1'b0;
        req.addr        <= '0;
        req.prefix_mask <= '0;
        req.hop_mac     <= '0;
        req.port_in     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, broadcast with ignored fields set, near broadcast
        dir_lookup(32'h0000_0000, 1'b1, RES_MISS, 1'b0);
        dir_lookup(ADDR_ONES, 1'b1, RES_FLOOD, 1'b1);
        dir_lookup(32'hFFFF_FFFE, 1'b1, RES_MISS, 1'b0);
        // default route: mask with a leading zero, junk prefix
        dir_write(4'd0, 1'b1, 32'h1357_9BDF, 32'h7FFF_FFFF, 48'h0, 2'd0);
        dir_lookup(32'h1234_5678, 1'b0, RES_MISS, 1'b0);
        dir_write(4'd15, 1'b1, 32'h0A00_0000, 32'hFF00_0000, MAC_ONES, 2'd3);
        dir_lookup(32'h0A01_0203, 1'b0, RES_MISS, 1'b0);
        // non-contiguous mask counts only its leading run
        dir_write(4'd3, 1'b1, 32'h0A01_0000, 32'hFFFF_00FF, 48'h1234_5678_9ABC, 2'd1);
        dir_lookup(32'h0A01_FF00, 1'b0, RES_MISS, 1'b0);
        // host route and its neighbor
        dir_write(4'd7, 1'b1, 32'hC0A8_0101, ADDR_ONES, 48'hA5A5_5A5A_0F0F, 2'd2);
        dir_lookup(32'hC0A8_0101, 1'b0, RES_MISS, 1'b0);
        dir_lookup(32'hC0A8_0100, 1'b0, RES_MISS, 1'b0);
        // equal lengths: lower slot wins, then removal hands back to slot 15
        dir_write(4'd9, 1'b1, 32'h0AFF_FFFF, 32'hFF00_0000, 48'h0000_0000_0001, 2'd2);
        dir_lookup(32'h0A7F_0000, 1'b0, RES_MISS, 1'b0);
        dir_write(4'd9, 1'b0, 32'h0AFF_FFFF, 32'hFF00_0000, 48'h0000_0000_0001, 2'd2);
        dir_lookup(32'h0A7F_0000, 1'b0, RES_MISS, 1'b0);
        // broadcast ignores a route that covers all ones
        dir_write(4'd1, 1'b1, ADDR_ONES, ADDR_ONES, 48'h0, 2'd0);
        dir_lookup(ADDR_ONES, 1'b1, RES_FLOOD, 1'b0);
        dir_lookup(32'h0A00_0001, 1'b0, RES_MISS, 1'b1);
        dir_write(4'd0, 1'b0, 32'h0, 32'h0, 48'h0, 2'd0);
        dir_lookup(32'h0102_0304, 1'b0, RES_MISS, 1'b0);
        dir_write(4'd2, 1'b1, 32'h0, ADDR_ONES, 48'h8000_0000_0000, 2'd1);
        dir_lookup(32'h0000_0000, 1'b0, RES_MISS, 1'b0);
        dir_write(4'd4, 1'b1, 32'h8000_0000, 32'h8000_0000, 48'h0000_FFFF_0000, 2'd3);
        dir_lookup(32'hC000_0000, 1'b0, RES_MISS, 1'b0);

        foreach (directed_rows[i])
            offer(directed_rows[i], 1'b1);

        // Random traffic: overlapping routes and lookups aimed at them
        burst = 0;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == HOLD_AT) begin
                hold_go = 1'b1;
                burst   = HOLD_BURST;
            end
            if (k == DRAIN_AT) begin
                req.valid <= 1'b0;
                do @(posedge i_clk); while (answers_q.size() != 0);
            end
            if (k == RAND_ITEMS - CALM_TAIL)
                calm = 1'b1;

            wide                = {$urandom, $urandom};
            row.fixed           = 1'b0;
            row.want            = RES_MISS;
            row.req.entry_index = $urandom_range(0, ENTRIES - 1);
            row.req.entry_valid = $urandom_range(0, 1);
            row.req.addr        = $urandom;
            row.req.prefix_mask = $urandom;
            row.req.hop_mac     = wide[MAC_W-1:0];
            row.req.port_in     = $urandom_range(0, NUM_PORTS - 1);
            pick                = $urandom_range(0, 99);
            s                   = $urandom_range(0, ENTRIES - 1);

            if (pick < 45) begin
                row.req.cmd         = CMD_WRITE;
                row.req.entry_valid = ($urandom_range(0, 7) != 0);
                case ($urandom_range(0, 2))
                    0: run = 8 * $urandom_range(0, 4);
                    1: run = $urandom_range(0, 32);
                    default: run = $urandom_range(0, 4) + 8 * $urandom_range(0, 3);
                endcase
                keep = run_keep(run);
                // sit under or over an existing route
                if ($urandom_range(0, 1) == 1 && tbl_on[s])
                    row.req.addr = (tbl_prefix[s] & keep) | (row.req.addr & ~keep);
                case ($urandom_range(0, 3))
                    0, 1: row.req.prefix_mask = keep;
                    2: row.req.prefix_mask = keep | ($urandom & (~keep >> 1));
                    default: ;  // fully random mask
                endcase
            end else begin
                row.req.cmd = CMD_LOOKUP;
                if (pick < 50) begin
                    row.req.addr = ADDR_ONES;
                end else if (pick < 53) begin
                    row.req.addr = ADDR_ONES ^ (32'h1 << $urandom_range(0, 31));
                end else if (pick < 88 && tbl_on[s]) begin
                    run          = mask_run_len(tbl_mask[s]);
                    keep         = run_keep(run);
                    row.req.addr = (tbl_prefix[s] & keep) | ($urandom & ~keep);
                    // near miss: flip one bit inside the prefix
                    if (run > 0 && $urandom_range(0, 4) == 0)
                        row.req.addr ^= 32'h1 << (32 - $urandom_range(1, run));
                end
            end

            offer(row, !calm && burst == 0);
            if (burst > 0)
                burst--;
        end

        req.valid <= 1'b0;
        do @(posedge i_clk); while (answers_q.size() != 0);
        repeat (CHAIN_LAT + 8) @(posedge i_clk);
        if (bad_fields == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off
    initial begin : result_drain
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                rsp.ready <= 1'b1;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin : result_check
        route_result_t want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (answers_q.size() == 0) begin
                $error("unexpected result: hit=%0b broadcast=%0b next_hop=%h",
                       rsp.hit, rsp.broadcast, rsp.next_hop);
                bad_fields++;
            end else begin
                want = answers_q.pop_front();
                if (rsp.hit !== want.hit) begin
                    $error("hit: expected %0b, actual %0b", want.hit, rsp.hit);
                    bad_fields++;
                end
                if (rsp.broadcast !== want.broadcast) begin
                    $error("broadcast: expected %0b, actual %0b",
                           want.broadcast, rsp.broadcast);
                    bad_fields++;
                end
                if (rsp.next_hop !== want.next_hop) begin
                    $error("next_hop: expected %h, actual %h", want.next_hop, rsp.next_hop);
                    bad_fields++;
                end
                if (rsp.out_port !== want.out_port) begin
                    $error("out_port: expected %0d, actual %0d", want.out_port, rsp.out_port);
                    bad_fields++;
                end
                if (rsp.prefix_len !== want.prefix_len) begin
                    $error("prefix_len: expected %0d, actual %0d",
                           want.prefix_len, rsp.prefix_len);
                    bad_fields++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== longest_prefix_route_lookup.f =====
rtl/lpr_pkg.sv
rtl/lpr_if.sv
rtl/lpr_cell.sv
rtl/longest_prefix_route_lookup.sv
dv/testbench.sv
